// ===== design/sgns_pkg.sv =====
// Shared types, constants and arithmetic helpers for the skip-gram update engine.
package sgns_pkg;

    localparam int FEATURES_DEF = 100;
    localparam int VOCAB_DEF    = 4096;

    localparam int WORD_W   = 12;
    localparam int FI_W     = 7;
    localparam int WEIGHT_W = 16;
    localparam int GAIN_W   = 18;
    localparam int LR_W     = 16;

    localparam logic [LR_W-1:0] LR_RESET = 16'd1638;

    // dot product saturation bound, 10.0 in Q.24
    localparam logic signed [63:0] SIG_SAT   = 64'sd167772160;
    localparam logic [16:0]        LOG2E_Q16 = 17'd94548;
    localparam logic [16:0]        ONE_Q16   = 17'd65536;

    typedef enum logic [1:0] {
        ACT_TRAIN  = 2'd0,
        ACT_WR_IN  = 2'd1,
        ACT_WR_OUT = 2'd2,
        ACT_RD_IN  = 2'd3
    } action_t;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_BASE,
        S_ACCESS,
        S_RDWAIT,
        S_DOT,
        S_GAIN,
        S_UPD,
        S_APPLY,
        S_DONE
    } ctrl_state_t;

    typedef enum logic [2:0] {
        G_IDLE,
        G_MUL,
        G_INTERP,
        G_SHIFT,
        G_DIV,
        G_SIG,
        G_GAIN,
        G_ROUND
    } gain_state_t;

    typedef struct packed {
        logic            start;
        logic            positive;
        logic [LR_W-1:0] learning_rate;
    } gain_ctl_t;

    // 2^(-j/16) in Q.16
    function automatic logic [16:0] pow2_neg(input logic [4:0] j);
        logic [16:0] v;
        case (j)
            5'd0:    v = 17'd65536;
            5'd1:    v = 17'd62757;
            5'd2:    v = 17'd60097;
            5'd3:    v = 17'd57548;
            5'd4:    v = 17'd55109;
            5'd5:    v = 17'd52773;
            5'd6:    v = 17'd50535;
            5'd7:    v = 17'd48393;
            5'd8:    v = 17'd46341;
            5'd9:    v = 17'd44376;
            5'd10:   v = 17'd42495;
            5'd11:   v = 17'd40693;
            5'd12:   v = 17'd38968;
            5'd13:   v = 17'd37316;
            5'd14:   v = 17'd35734;
            5'd15:   v = 17'd34219;
            default: v = 17'd32768;
        endcase
        return v;
    endfunction

    // scale down by 2^16, round to nearest, halves away from zero
    function automatic logic signed [47:0] round_q16(input logic signed [47:0] p);
        logic [47:0] m;
        logic [47:0] q;
        m = p[47] ? 48'(-p) : 48'(p);
        q = (m + 48'd32768) >> 16;
        return p[47] ? -$signed(q) : $signed(q);
    endfunction

    function automatic logic signed [15:0] sat16(input logic signed [47:0] v);
        logic signed [15:0] r;
        if (v > 48'sd32767)
            r = 16'sh7fff;
        else if (v < -48'sd32768)
            r = 16'sh8000;
        else
            r = v[15:0];
        return r;
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [47:0] v);
        logic signed [31:0] r;
        if (v > 48'sd2147483647)
            r = 32'sh7fffffff;
        else if (v < -48'sd2147483648)
            r = 32'sh80000000;
        else
            r = v[31:0];
        return r;
    endfunction

endpackage

// ===== design/sgns_gain.sv =====
// Sigmoid and gain unit: saturating sigmoid of the dot product, taken from the label (1 or 0), times learning rate.
module sgns_gain #(
    parameter int DOT_W = 39
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  sgns_pkg::gain_ctl_t       ctl,
    input  logic signed [DOT_W-1:0]   dot,
    output logic                      done,
    output logic signed [sgns_pkg::GAIN_W-1:0] gain
);

    sgns_pkg::gain_state_t state_reg, state_next;

    logic                 neg_reg;
    logic                 pos_reg;
    logic [15:0]          lr_reg;
    logic [19:0]          x_reg;
    logic [19:0]          t_reg;
    logic [16:0]          v_reg;
    logic [3:0]           n_reg;
    logic [17:0]          den_reg;
    logic [32:0]          num_reg;
    logic [18:0]          rem_reg;
    logic [16:0]          quo_reg;
    logic [5:0]           bit_reg;
    logic [16:0]          sig_reg;
    logic signed [34:0]   prod_reg;
    logic signed [17:0]   gain_reg;
    logic                 done_reg;

    logic signed [63:0]   dot64;
    logic [63:0]          mag;
    logic [16:0]          tbl_hi;
    logic [16:0]          tbl_lo;
    logic [28:0]          interp;
    logic [16:0]          e_val;
    logic [17:0]          den_val;
    logic [18:0]          rem_try;
    logic                 q_bit;
    logic signed [17:0]   diff;

    assign dot64   = 64'(dot);
    assign mag     = dot64[63] ? 64'(-dot64) : 64'(dot64);
    assign tbl_hi  = sgns_pkg::pow2_neg({1'b0, t_reg[15:12]});
    assign tbl_lo  = sgns_pkg::pow2_neg(5'({1'b0, t_reg[15:12]}) + 5'd1);
    assign interp  = 29'(tbl_hi - tbl_lo) * 29'(t_reg[11:0]);
    assign e_val   = v_reg >> n_reg;
    assign den_val = 18'(sgns_pkg::ONE_Q16) + 18'(e_val);
    assign rem_try = {rem_reg[17:0], num_reg[32]};
    assign q_bit   = rem_try >= {1'b0, den_reg};
    assign diff    = (pos_reg ? 18'sd65536 : 18'sd0) - $signed({1'b0, sig_reg});
    assign done    = done_reg;
    assign gain    = gain_reg;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            sgns_pkg::G_IDLE:
            begin
                if (ctl.start)
                begin
                    if (dot64 > sgns_pkg::SIG_SAT || dot64 < -sgns_pkg::SIG_SAT)
                        state_next = sgns_pkg::G_GAIN;
                    else
                        state_next = sgns_pkg::G_MUL;
                end
            end
            sgns_pkg::G_MUL:    state_next = sgns_pkg::G_INTERP;
            sgns_pkg::G_INTERP: state_next = sgns_pkg::G_SHIFT;
            sgns_pkg::G_SHIFT:  state_next = sgns_pkg::G_DIV;
            sgns_pkg::G_DIV:
            begin
                if (bit_reg == 6'd1)
                    state_next = sgns_pkg::G_SIG;
            end
            sgns_pkg::G_SIG:    state_next = sgns_pkg::G_GAIN;
            sgns_pkg::G_GAIN:   state_next = sgns_pkg::G_ROUND;
            sgns_pkg::G_ROUND:  state_next = sgns_pkg::G_IDLE;
            default:            state_next = sgns_pkg::G_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= sgns_pkg::G_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= (state_reg == sgns_pkg::G_ROUND);
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            sgns_pkg::G_IDLE:
            begin
                neg_reg <= dot64[63];
                pos_reg <= ctl.positive;
                lr_reg  <= ctl.learning_rate;
                x_reg   <= mag[27:8];
                sig_reg <= (dot64 > sgns_pkg::SIG_SAT) ? sgns_pkg::ONE_Q16 : 17'd0;
            end
            sgns_pkg::G_MUL:
                t_reg <= 20'((37'(x_reg) * 37'(sgns_pkg::LOG2E_Q16)) >> 16);
            sgns_pkg::G_INTERP:
            begin
                v_reg <= tbl_hi - 17'(interp >> 12);
                n_reg <= t_reg[19:16];
            end
            sgns_pkg::G_SHIFT:
            begin
                den_reg <= den_val;
                num_reg <= 33'h1_0000_0000 + 33'(den_val >> 1);
                rem_reg <= '0;
                quo_reg <= '0;
                bit_reg <= 6'd33;
            end
            sgns_pkg::G_DIV:
            begin
                // restoring division, one quotient bit per cycle
                rem_reg <= q_bit ? rem_try - {1'b0, den_reg} : rem_try;
                num_reg <= {num_reg[31:0], 1'b0};
                quo_reg <= {quo_reg[15:0], q_bit};
                bit_reg <= bit_reg - 6'd1;
            end
            sgns_pkg::G_SIG:
                sig_reg <= neg_reg ? sgns_pkg::ONE_Q16 - quo_reg : quo_reg;
            sgns_pkg::G_GAIN:
                prod_reg <= 35'(diff) * 35'($signed({1'b0, lr_reg}));
            sgns_pkg::G_ROUND:
                gain_reg <= 18'(sgns_pkg::round_q16(48'(prod_reg)));
            default:
            begin
            end
        endcase
    end

endmodule

// ===== design/skipgram_negative_sampling_update_top.sv =====
// Top level of the skip-gram negative-sampling update engine with its embedding memories.
//
//  channel  dir  handshake          payload
//  s_*      in   s_tvalid/s_tready  tdata: context_word, target_word, feature_index,
//                                   weight_value; tuser: action, is_positive;
//                                   tlast: last_in_group
//  m_*      out  m_tvalid/m_tready  tdata: read_value, step_gain; tuser: skipped
//  cfg_*    in   cfg_valid/ready    cfg_data: learning_rate
//
//  A write or read passes S_BASE, S_ACCESS (and S_RDWAIT for a read) and S_DONE. A train
//  item that is not skipped runs a dot pass, the sigmoid unit with a 33-step divider and an
//  update pass; the last item of a group adds an input row update and accumulator clear.
//  After reset the accumulator memory is cleared before s_tready goes high.
//  One item is in flight; the next is taken while the result waits in m_tdata.
module skipgram_negative_sampling_update_top #(
    parameter int FEATURES = sgns_pkg::FEATURES_DEF,
    parameter int VOCAB    = sgns_pkg::VOCAB_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // context_word, target_word, feature_index, weight_value
    input  logic [2:0]  s_tuser,   // action, is_positive
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // read_value, step_gain
    output logic        m_tuser,   // skipped
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] cfg_data
);

    localparam int CNT_W  = (FEATURES > 1) ? $clog2(FEATURES) : 1;
    localparam int CNTF_W = $clog2(FEATURES + 1);
    localparam int DEPTH  = VOCAB * FEATURES;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int DOT_W  = 32 + CNTF_W;
    localparam logic [CNTF_W-1:0] FEAT_CNT = CNTF_W'(FEATURES);
    localparam logic [ADDR_W-1:0] FEAT_A   = ADDR_W'(FEATURES);

    sgns_pkg::ctrl_state_t state_reg, state_next;

    sgns_pkg::action_t  act_reg;
    logic [11:0]        cw_reg;
    logic [11:0]        tw_reg;
    logic               pos_reg;
    logic               last_reg;
    logic [6:0]         fi_reg;
    logic signed [15:0] wv_reg;

    logic [15:0]        lr_reg;
    logic [11:0]        gpt_reg;
    logic [ADDR_W-1:0]  base1_reg;
    logic [ADDR_W-1:0]  base2_reg;
    logic [CNTF_W-1:0]  cnt_reg;
    logic               p1_reg;
    logic               p2_reg;
    logic [CNT_W-1:0]   idx1_reg;
    logic [CNT_W-1:0]   idx2_reg;

    logic signed [31:0]     prod_reg;
    logic signed [DOT_W-1:0] dot_reg;
    logic signed [33:0]     pa_reg;
    logic signed [33:0]     pb_reg;
    logic signed [15:0]     w2_reg;
    logic signed [31:0]     accd_reg;

    logic signed [15:0] in_q_reg;
    logic signed [15:0] out_q_reg;
    logic signed [31:0] acc_q_reg;

    logic signed [15:0] res_read_reg;
    logic signed [17:0] res_gain_reg;
    logic               res_skip_reg;
    logic               m_tvalid_reg;
    logic [39:0]        m_tdata_reg;
    logic               m_tuser_reg;

    logic signed [15:0] in_mem  [DEPTH];
    logic signed [15:0] out_mem [DEPTH];
    logic signed [31:0] acc_mem [FEATURES];

    logic               cw_ok;
    logic               tw_ok;
    logic               fi_ok;
    logic               skip;
    logic               train_go;
    logic               issue;
    logic               drained;
    logic               load_out;
    logic               gain_start;
    logic               gain_done;
    logic signed [17:0] gain;
    sgns_pkg::gain_ctl_t gain_ctl;

    logic [ADDR_W-1:0]  item_addr;
    logic [ADDR_W-1:0]  in_rd_addr;
    logic [ADDR_W-1:0]  out_rd_addr;
    logic               in_we;
    logic [ADDR_W-1:0]  in_wa;
    logic signed [15:0] in_wd;
    logic               out_we;
    logic [ADDR_W-1:0]  out_wa;
    logic signed [15:0] out_wd;
    logic               acc_we;
    logic [CNT_W-1:0]   acc_wa;
    logic signed [31:0] acc_wd;

    assign cw_ok    = 32'(cw_reg) < 32'(VOCAB);
    assign tw_ok    = 32'(tw_reg) < 32'(VOCAB);
    assign fi_ok    = 32'(fi_reg) < 32'(FEATURES);
    assign skip     = (act_reg == sgns_pkg::ACT_TRAIN) && !pos_reg && (tw_reg == gpt_reg);
    assign train_go = !skip && cw_ok && tw_ok;
    assign drained  = (cnt_reg == FEAT_CNT) && !p1_reg && !p2_reg;

    assign s_tready  = (state_reg == sgns_pkg::S_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;
    assign m_tuser   = m_tuser_reg;

    assign item_addr   = base1_reg + ADDR_W'(fi_reg);
    assign in_rd_addr  = (state_reg == sgns_pkg::S_ACCESS) ? item_addr
                                                          : base1_reg + ADDR_W'(cnt_reg);
    assign out_rd_addr = base2_reg + ADDR_W'(cnt_reg);

    assign gain_ctl.start         = gain_start;
    assign gain_ctl.positive      = pos_reg;
    assign gain_ctl.learning_rate = lr_reg;

    sgns_gain #(
        .DOT_W (DOT_W)
    ) u_gain (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (gain_ctl),
        .dot   (dot_reg),
        .done  (gain_done),
        .gain  (gain)
    );

    always_comb
    begin
        state_next = state_reg;
        issue      = 1'b0;
        gain_start = 1'b0;
        load_out   = 1'b0;
        case (state_reg)
            sgns_pkg::S_CLEAR:
            begin
                issue = (cnt_reg != FEAT_CNT);
                if (cnt_reg == FEAT_CNT)
                    state_next = sgns_pkg::S_IDLE;
            end
            sgns_pkg::S_IDLE:
            begin
                if (s_tvalid)
                    state_next = sgns_pkg::S_BASE;
            end
            sgns_pkg::S_BASE:
            begin
                if (act_reg != sgns_pkg::ACT_TRAIN)
                    state_next = sgns_pkg::S_ACCESS;
                else if (train_go)
                    state_next = sgns_pkg::S_DOT;
                else if (last_reg)
                    state_next = sgns_pkg::S_APPLY;
                else
                    state_next = sgns_pkg::S_DONE;
            end
            sgns_pkg::S_ACCESS:
            begin
                if (act_reg == sgns_pkg::ACT_RD_IN)
                    state_next = sgns_pkg::S_RDWAIT;
                else
                    state_next = sgns_pkg::S_DONE;
            end
            sgns_pkg::S_RDWAIT:
                state_next = sgns_pkg::S_DONE;
            sgns_pkg::S_DOT:
            begin
                issue = (cnt_reg != FEAT_CNT);
                if (drained)
                begin
                    gain_start = 1'b1;
                    state_next = sgns_pkg::S_GAIN;
                end
            end
            sgns_pkg::S_GAIN:
            begin
                if (gain_done)
                    state_next = sgns_pkg::S_UPD;
            end
            sgns_pkg::S_UPD:
            begin
                issue = (cnt_reg != FEAT_CNT);
                if (drained)
                    state_next = last_reg ? sgns_pkg::S_APPLY : sgns_pkg::S_DONE;
            end
            sgns_pkg::S_APPLY:
            begin
                issue = (cnt_reg != FEAT_CNT);
                if (drained)
                    state_next = sgns_pkg::S_DONE;
            end
            sgns_pkg::S_DONE:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    load_out   = 1'b1;
                    state_next = sgns_pkg::S_IDLE;
                end
            end
            default:
                state_next = sgns_pkg::S_IDLE;
        endcase
    end

    // memory write selection
    always_comb
    begin
        in_we  = 1'b0;
        in_wa  = item_addr;
        in_wd  = wv_reg;
        out_we = 1'b0;
        out_wa = item_addr;
        out_wd = wv_reg;
        acc_we = 1'b0;
        acc_wa = cnt_reg[CNT_W-1:0];
        acc_wd = '0;
        case (state_reg)
            sgns_pkg::S_CLEAR:
                acc_we = issue;
            sgns_pkg::S_ACCESS:
            begin
                in_we  = (act_reg == sgns_pkg::ACT_WR_IN) && cw_ok && fi_ok;
                out_we = (act_reg == sgns_pkg::ACT_WR_OUT) && cw_ok && fi_ok;
            end
            sgns_pkg::S_UPD:
            begin
                out_we = p2_reg;
                out_wa = base2_reg + ADDR_W'(idx2_reg);
                out_wd = sgns_pkg::sat16(48'(w2_reg) + sgns_pkg::round_q16(48'(pb_reg)));
                acc_we = p2_reg;
                acc_wa = idx2_reg;
                acc_wd = sgns_pkg::sat32(48'(accd_reg) + sgns_pkg::round_q16(48'(pa_reg)));
            end
            sgns_pkg::S_APPLY:
            begin
                // accumulator is cleared even when the context row is out of range
                in_we  = p1_reg && cw_ok;
                in_wa  = base1_reg + ADDR_W'(idx1_reg);
                in_wd  = sgns_pkg::sat16(48'(in_q_reg) + 48'(acc_q_reg));
                acc_we = p1_reg;
                acc_wa = idx1_reg;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (in_we)
            in_mem[in_wa] <= in_wd;
        in_q_reg <= in_mem[in_rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (out_we)
            out_mem[out_wa] <= out_wd;
        out_q_reg <= out_mem[out_rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (acc_we)
            acc_mem[acc_wa] <= acc_wd;
        acc_q_reg <= acc_mem[cnt_reg[CNT_W-1:0]];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= sgns_pkg::S_CLEAR;
            cnt_reg      <= '0;
            p1_reg       <= 1'b0;
            p2_reg       <= 1'b0;
            m_tvalid_reg <= 1'b0;
            lr_reg       <= sgns_pkg::LR_RESET;
            gpt_reg      <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (issue)
                cnt_reg <= cnt_reg + CNTF_W'(1);
            else if (state_next != state_reg)
                cnt_reg <= '0;
            p1_reg <= issue && (state_reg != sgns_pkg::S_CLEAR);
            p2_reg <= p1_reg;
            if (load_out)
                m_tvalid_reg <= 1'b1;
            else if (m_tready)
                m_tvalid_reg <= 1'b0;
            if (cfg_valid)
                lr_reg <= cfg_data;
            if (state_reg == sgns_pkg::S_BASE && act_reg == sgns_pkg::ACT_TRAIN && pos_reg)
                gpt_reg <= tw_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            act_reg  <= sgns_pkg::action_t'(s_tuser[1:0]);
            pos_reg  <= s_tuser[2];
            last_reg <= s_tlast;
            cw_reg   <= s_tdata[11:0];
            tw_reg   <= s_tdata[23:12];
            fi_reg   <= s_tdata[30:24];
            wv_reg   <= s_tdata[46:31];
        end

        idx1_reg <= cnt_reg[CNT_W-1:0];
        idx2_reg <= idx1_reg;

        if (state_reg == sgns_pkg::S_BASE)
        begin
            base1_reg    <= ADDR_W'(cw_reg) * FEAT_A;
            base2_reg    <= ADDR_W'(tw_reg) * FEAT_A;
            dot_reg      <= '0;
            res_read_reg <= '0;
            res_gain_reg <= '0;
            res_skip_reg <= skip;
        end

        if (state_reg == sgns_pkg::S_DOT)
        begin
            prod_reg <= 32'(in_q_reg) * 32'(out_q_reg);
            if (p2_reg)
                dot_reg <= dot_reg + DOT_W'(prod_reg);
        end

        if (state_reg == sgns_pkg::S_UPD)
        begin
            pa_reg   <= 34'(gain) * 34'(out_q_reg);
            pb_reg   <= 34'(gain) * 34'(in_q_reg);
            w2_reg   <= out_q_reg;
            accd_reg <= acc_q_reg;
        end

        if (state_reg == sgns_pkg::S_RDWAIT)
            res_read_reg <= (cw_ok && fi_ok) ? in_q_reg : 16'sd0;

        if (state_reg == sgns_pkg::S_GAIN && gain_done)
            res_gain_reg <= gain;

        if (load_out)
        begin
            m_tdata_reg <= {6'b0, res_gain_reg, res_read_reg};
            m_tuser_reg <= res_skip_reg;
        end
    end

endmodule

// ===== tb/skipgram_negative_sampling_update_top_test.sv =====
// Testbench for the skip-gram update engine: bit-exact predictor, stream driver and monitor.
module skipgram_negative_sampling_update_top_test;
    import sgns_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int NF = 100;
    localparam int NV = 4096;
    localparam int IDLE_LIMIT = 20000;
    localparam int DRAIN_CYCLES = 400;

    typedef struct {
        action_t     act;
        logic [11:0] cw;
        logic [11:0] tw;
        logic        pos;
        logic        last;
        logic [6:0]  fi;
        logic [15:0] wv;
    } word_item_t;

    typedef struct {
        logic [15:0] read_value;
        logic [17:0] gain;
        logic        skipped;
    } update_result_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [47:0] s_tdata = '0;
    logic [2:0]  s_tuser = '0;
    logic        s_tlast = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;
    logic        m_tuser;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [15:0] cfg_data = '0;

    skipgram_negative_sampling_update_top dut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .s_tuser(s_tuser), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
    );

    initial forever #5 clk = ~clk;

    // predictor state
    logic signed [15:0] in_tab  [0:NV*NF-1];
    logic signed [15:0] out_tab [0:NV*NF-1];
    longint             grad_acc [0:NF-1];
    logic [11:0]        pos_target = '0;
    longint             rate = 1638;

    word_item_t     pending_words [$];
    update_result_t expected_results [$];
    int             mismatches = 0;
    int             results_seen = 0;

    // generator bookkeeping: which input-table entries have been written
    bit gen_written [int];
    int written_keys [$];
    int in_rows [4];
    int out_rows [4];

    function automatic longint sat_lim(longint v, longint lo, longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function automatic longint q16_round(longint p);
        longint m;
        m = p < 0 ? -p : p;
        m = (m + 32768) >>> 16;
        return p < 0 ? -m : m;
    endfunction

    function automatic longint sigmoid_q16(longint dot);
        longint unsigned pow2 [0:16] = '{65536, 62757, 60097, 57548, 55109, 52773, 50535,
            48393, 46341, 44376, 42495, 40693, 38968, 37316, 35734, 34219, 32768};
        longint unsigned mag, x, t, v, e, den, s;
        int unsigned n, r, j, fr;
        if (dot > (longint'(10) <<< 24))
            return 65536;
        if (dot < -(longint'(10) <<< 24))
            return 0;
        mag = dot < 0 ? -dot : dot;
        x = mag >> 8;
        t = (x * 94548) >> 16;
        n = t >> 16;
        r = t & 16'hFFFF;
        j = r >> 12;
        fr = r & 12'hFFF;
        v = pow2[j] - (((pow2[j] - pow2[j+1]) * fr) >> 12);
        e = n < 63 ? v >> n : 0;
        den = 65536 + e;
        s = ((64'd1 << 32) + (den >> 1)) / den;
        return dot < 0 ? 65536 - longint'(s) : longint'(s);
    endfunction

    function automatic update_result_t apply_word(word_item_t w);
        update_result_t res;
        int l1, l2;
        longint dot, gain, w1, w2;
        res = '{read_value: '0, gain: '0, skipped: 1'b0};
        l1 = int'(w.cw) * NF;
        l2 = int'(w.tw) * NF;
        gain = 0;
        case (w.act)
            ACT_WR_IN:  if (w.fi < NF) in_tab[l1 + w.fi] = w.wv;
            ACT_WR_OUT: if (w.fi < NF) out_tab[l1 + w.fi] = w.wv;
            ACT_RD_IN:  if (w.fi < NF) res.read_value = in_tab[l1 + w.fi];
            default:
            begin
                res.skipped = !w.pos && w.tw == pos_target;
                if (w.pos)
                    pos_target = w.tw;
                if (!res.skipped)
                begin
                    dot = 0;
                    for (int c = 0; c < NF; c++)
                        dot += longint'(in_tab[l1 + c]) * longint'(out_tab[l2 + c]);
                    gain = q16_round(((w.pos ? 65536 : 0) - sigmoid_q16(dot)) * rate);
                    for (int c = 0; c < NF; c++)
                    begin
                        w1 = in_tab[l1 + c];
                        w2 = out_tab[l2 + c];
                        grad_acc[c] = sat_lim(grad_acc[c] + q16_round(gain * w2),
                                              -64'sd2147483648, 64'sd2147483647);
                        out_tab[l2 + c] = 16'(sat_lim(w2 + q16_round(gain * w1),
                                                      -32768, 32767));
                    end
                end
                if (w.last)
                begin
                    for (int c = 0; c < NF; c++)
                    begin
                        in_tab[l1 + c] = 16'(sat_lim(in_tab[l1 + c] + grad_acc[c],
                                                     -32768, 32767));
                        grad_acc[c] = 0;
                    end
                end
            end
        endcase
        res.gain = 18'(gain);
        return res;
    endfunction

    task automatic push_word(action_t act, int cw, int tw, bit pos, bit last, int fi, int wv);
        word_item_t w;
        w = '{act: act, cw: 12'(cw), tw: 12'(tw), pos: pos, last: last,
              fi: 7'(fi), wv: 16'(wv)};
        if (act == ACT_WR_IN && fi < NF && !gen_written.exists(cw * NF + fi))
        begin
            gen_written[cw * NF + fi] = 1'b1;
            written_keys.push_back(cw * NF + fi);
        end
        pending_words.push_back(w);
    endtask

    task automatic fill_row(action_t act, int row, int lo, int hi);
        for (int f = 0; f < NF; f++)
            push_word(act, row, $urandom, $urandom, $urandom, f, $urandom_range(hi - lo) + lo);
    endtask

    // well-formed group: one positive, then negatives, last flag on the final one
    task automatic push_group();
        int cw, n, ptw;
        cw = in_rows[$urandom_range(3)];
        n = $urandom_range(5, 1);
        ptw = out_rows[$urandom_range(3)];
        push_word(ACT_TRAIN, cw, ptw, 1, n == 1, $urandom, $urandom);
        for (int k = 1; k < n; k++)
            push_word(ACT_TRAIN, cw, out_rows[$urandom_range(3)], 0, k == n - 1,
                      $urandom, $urandom);
    endtask

    task automatic push_random(int count);
        int pick, key;
        for (int k = 0; k < count; k++)
        begin
            pick = $urandom_range(99);
            if (pick < 55)
                push_group();
            else if (pick < 65)
                push_word(ACT_TRAIN, in_rows[$urandom_range(3)], out_rows[$urandom_range(3)],
                          $urandom, $urandom, $urandom, $urandom);
            else if (pick < 77)
                push_word(ACT_WR_IN, $urandom, $urandom, $urandom, $urandom,
                          $urandom_range(127), $urandom);
            else if (pick < 85)
                push_word(ACT_WR_OUT, out_rows[$urandom_range(3)], $urandom, $urandom,
                          $urandom, $urandom_range(127), $urandom_range(4000) - 2000);
            else if ($urandom_range(3) != 0)
            begin
                key = written_keys[$urandom_range(written_keys.size() - 1)];
                push_word(ACT_RD_IN, key / NF, $urandom, $urandom, $urandom, key % NF,
                          $urandom);
            end
            else
                push_word(ACT_RD_IN, $urandom, $urandom, $urandom, $urandom,
                          $urandom_range(127, NF), $urandom);
        end
    endtask

    task automatic wait_drained();
        while (pending_words.size() != 0 || expected_results.size() != 0 || s_tvalid)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_rate(logic [15:0] v);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data <= v;
        do @(posedge clk); while (!cfg_ready);
        rate = v;
        cfg_valid <= 1'b0;
    endtask

    // sender: bursts and gaps
    int burst_left = 4;
    int gap_left = 0;
    always @(posedge clk)
    begin
        if (!rst_n)
            s_tvalid <= 1'b0;
        else
        begin
            if (s_tvalid && s_tready)
                expected_results.push_back(apply_word(word_item_t'{
                    act: action_t'(s_tuser[1:0]), cw: s_tdata[11:0], tw: s_tdata[23:12],
                    pos: s_tuser[2], last: s_tlast, fi: s_tdata[30:24],
                    wv: s_tdata[46:31]}));
            if (!(s_tvalid && !s_tready))
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    s_tvalid <= 1'b0;
                end
                else if (pending_words.size() != 0)
                begin
                    word_item_t w;
                    w = pending_words.pop_front();
                    s_tdata <= {1'b0, w.wv, w.fi, w.tw, w.cw};
                    s_tuser <= {w.pos, w.act};
                    s_tlast <= w.last;
                    s_tvalid <= 1'b1;
                    burst_left--;
                    if (burst_left <= 0)
                    begin
                        burst_left = $urandom_range(12, 1);
                        gap_left = $urandom_range(3) == 0 ? 0 : $urandom_range(400);
                    end
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // receiver: stall pattern per window, one long hold-off
    int window_left = 0;
    int stall_mode = 0;
    int hold_left = 0;
    bit held_once = 1'b0;
    always @(posedge clk)
    begin
        if (!held_once && results_seen == 100)
        begin
            held_once = 1'b1;
            hold_left = 3000;
        end
        if (window_left == 0)
        begin
            window_left = $urandom_range(64, 8);
            stall_mode = $urandom_range(2);
        end
        window_left--;
        if (hold_left > 0)
        begin
            hold_left--;
            m_tready <= 1'b0;
        end
        else
            m_tready <= stall_mode == 0 ? 1'b1 :
                        stall_mode == 1 ? 1'($urandom) : ($urandom_range(3) == 0);
    end

    // result checker
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            update_result_t exp_r;
            results_seen++;
            if (expected_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected word: read=%h gain=%h skip=%b",
                             m_tdata[15:0], m_tdata[33:16], m_tuser);
            end
            else
            begin
                exp_r = expected_results.pop_front();
                if (m_tdata[15:0] !== exp_r.read_value || m_tdata[33:16] !== exp_r.gain ||
                    m_tuser !== exp_r.skipped)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: read %h/%h gain %h/%h skip %b/%b (exp/got)",
                                 exp_r.read_value, m_tdata[15:0], exp_r.gain,
                                 m_tdata[33:16], exp_r.skipped, m_tuser);
                end
            end
        end
    end

    // watchdog on cycles without any handshake
    int quiet_cycles = 0;
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= IDLE_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    initial
    begin
        for (int c = 0; c < NF; c++)
            grad_acc[c] = 0;
        in_rows = '{0, 4095, $urandom_range(4094, 1), $urandom_range(4094, 1)};
        out_rows[0] = 0;
        out_rows[1] = 4095;
        out_rows[2] = $urandom_range(2000, 1);
        out_rows[3] = $urandom_range(4094, 2001);
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // rows used for training, including saturating ones
        fill_row(ACT_WR_IN, in_rows[0], -1500, 1500);
        fill_row(ACT_WR_IN, in_rows[1], 20000, 20000);
        fill_row(ACT_WR_IN, in_rows[2], -1500, 1500);
        fill_row(ACT_WR_IN, in_rows[3], -3000, 3000);
        fill_row(ACT_WR_OUT, out_rows[0], -1500, 1500);
        fill_row(ACT_WR_OUT, out_rows[1], 20000, 20000);
        fill_row(ACT_WR_OUT, out_rows[2], -20000, -20000);
        fill_row(ACT_WR_OUT, out_rows[3], -1500, 1500);

        // directed
        push_word(ACT_WR_IN, in_rows[2], 0, 0, 0, 7, 32767);
        push_word(ACT_RD_IN, in_rows[2], 0, 0, 0, 7, 0);
        push_word(ACT_WR_IN, in_rows[2], 0, 0, 0, 8, -32768);
        push_word(ACT_RD_IN, in_rows[2], 0, 0, 0, 8, 0);
        push_word(ACT_WR_IN, in_rows[2], 0, 0, 0, 110, 1234);
        push_word(ACT_RD_IN, in_rows[2], 0, 0, 0, 110, 0);
        push_word(ACT_RD_IN, 4095, 0, 0, 0, 127, 0);
        push_word(ACT_WR_OUT, out_rows[3], 0, 0, 0, 3, -32768);
        push_word(ACT_WR_OUT, out_rows[3], 0, 0, 0, 120, 5);
        push_word(ACT_TRAIN, in_rows[1], out_rows[1], 1, 1, 0, 0);
        push_word(ACT_TRAIN, in_rows[1], out_rows[2], 0, 1, 0, 0);
        push_word(ACT_TRAIN, in_rows[0], out_rows[0], 1, 0, 0, 0);
        push_word(ACT_TRAIN, in_rows[0], out_rows[0], 0, 0, 0, 0);
        push_word(ACT_TRAIN, in_rows[0], out_rows[3], 0, 0, 0, 0);
        push_word(ACT_TRAIN, in_rows[0], out_rows[0], 0, 1, 0, 0);
        push_word(ACT_TRAIN, in_rows[3], out_rows[3], 1, 0, 3, 0);
        push_word(ACT_TRAIN, in_rows[3], out_rows[3], 0, 1, 0, 0);
        push_random(40);
        wait_drained();

        write_rate(16'hFFFF);
        push_random(120);
        wait_drained();
        write_rate(16'h0000);
        push_random(60);
        wait_drained();
        write_rate(16'($urandom));
        push_random(120);
        wait_drained();
        write_rate(16'd1638);
        push_random(110);
        wait_drained();

        if (mismatches == 0 && expected_results.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

// ===== skipgram_negative_sampling_update_top.f =====
design/sgns_pkg.sv
design/sgns_gain.sv
design/skipgram_negative_sampling_update_top.sv
tb/skipgram_negative_sampling_update_top_test.sv
